>>> hw/rtl/rsp_pkg.sv
// Shared types and constants of the ramp/soak setpoint profiler.
`timescale 1ns / 1ps
package rsp_pkg;

  localparam int MAX_STEPS_DEF = 16;
  localparam int TEMP_W        = 16;
  localparam int TIME_W        = 32;
  localparam int CMD_W         = 3;
  localparam int IDX_OUT_W     = 4;
  // magnitude of end - start, also the width of the quotient
  localparam int MAG_W         = TEMP_W + 1;
  localparam int PROD_W        = MAG_W + TIME_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_TICK  = 3'd1,
    CMD_FWD   = 3'd2,
    CMD_BACK  = 3'd3,
    CMD_BEGIN = 3'd4,
    CMD_RESET = 3'd5,
    CMD_CLEAR = 3'd6
  } cmd_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] start_temp;
    logic signed [TEMP_W-1:0] end_temp;
    logic [TIME_W-1:0]        length;
    logic [TIME_W-1:0]        begin_time;
    logic [TIME_W-1:0]        due_time;
  } step_t;

  localparam int STEP_W = $bits(step_t);

endpackage

>>> hw/rtl/ramp_soak_setpoint_profiler_core.sv
// Top level of the ramp/soak setpoint profiler: command sequencer, step table, interpolator.
// Sequence: every item passes EXEC, RD (table read) and CHK before its result strobe.
// Tick: one more RD/CHK pass per finished step skipped, then, when a setpoint is produced,
//   the serial multiply and restoring divide in the interpolator.
// Throughput: one item at a time; busy is high from acceptance until the result strobe.
// Reset (rst_n low, synchronous): empty table, step 0, elapsed and total time zero.
`timescale 1ns / 1ps
module ramp_soak_setpoint_profiler_core #(
  parameter int MAX_STEPS = rsp_pkg::MAX_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rsp_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [rsp_pkg::TEMP_W-1:0]  in_start_temp,
  input  logic signed [rsp_pkg::TEMP_W-1:0]  in_end_temp,
  input  logic [rsp_pkg::TIME_W-1:0]         in_step_length_ms,
  input  logic [rsp_pkg::TIME_W-1:0]         in_delta_ms,
  output logic                               out_valid,
  output logic signed [rsp_pkg::TEMP_W-1:0]  out_setpoint,
  output logic                               out_setpoint_valid,
  output logic [rsp_pkg::IDX_OUT_W-1:0]      out_step_index,
  output logic                               out_accepted,
  output logic [rsp_pkg::TIME_W-1:0]         out_time_in_step
);
  import rsp_pkg::*;

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STEPS);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RD, S_CHK, S_INTERP} state_t;

  // sequencer state
  state_t                   state_r;
  cmd_t                     cmd_r;
  logic signed [TEMP_W-1:0] st_r;
  logic signed [TEMP_W-1:0] et_r;
  logic [TIME_W-1:0]        len_r;
  logic [TIME_W-1:0]        delta_r;
  logic                     acc_r;
  logic [TIME_W-1:0]        tis_r;

  // program state
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  cur_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [TIME_W-1:0] total_r;

  // result registers
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_sp_r;
  logic                     out_spv_r;
  logic [IDX_OUT_W-1:0]     out_idx_r;
  logic                     out_acc_r;
  logic [TIME_W-1:0]        out_tis_r;

  // step table port
  logic              ram_we;
  logic              ram_re;
  step_t             wr_step;
  logic [STEP_W-1:0] rd_bits;
  step_t             rd_step;

  // interpolator handshake
  logic                     ip_go;
  logic                     ip_done;
  logic signed [TEMP_W-1:0] ip_sp;

  logic [CNT_W-1:0]         cur_ext;
  logic [CNT_W-1:0]         cur_inc;
  logic                     in_range;
  logic [TIME_W:0]          tot_sum;
  logic [TIME_W:0]          el_sum;
  logic                     add_ok;
  logic [TIME_W-1:0]        tis_now;
  logic [TIME_W-1:0]        tis_gen;
  logic [IDX_W+IDX_OUT_W-1:0] idx_pad;

  always_comb begin
    cur_ext  = CNT_W'(cur_r);
    cur_inc  = cur_ext + 1'b1;
    in_range = (cur_ext < count_r);
    tot_sum  = {1'b0, total_r} + {1'b0, len_r};
    el_sum   = {1'b0, elapsed_r} + {1'b0, delta_r};
    add_ok   = (count_r < CNT_MAX) && (len_r != '0) && !tot_sum[TIME_W];
    rd_step  = step_t'(rd_bits);
    tis_now  = elapsed_r - rd_step.begin_time;
    // time into the current step, zero before its start or off the table
    tis_gen  = (in_range && elapsed_r >= rd_step.begin_time) ? tis_now : '0;
    idx_pad  = {{IDX_OUT_W{1'b0}}, cur_r};

    wr_step.start_temp = st_r;
    wr_step.end_temp   = et_r;
    wr_step.length     = len_r;
    wr_step.begin_time = total_r;
    wr_step.due_time   = tot_sum[TIME_W-1:0];

    ram_we = (state_r == S_EXEC) && (cmd_r == CMD_ADD) && add_ok;
    ram_re = (state_r == S_RD);
    ip_go  = (state_r == S_CHK) && (cmd_r == CMD_TICK) && (count_r != '0) &&
             (elapsed_r <= total_r) && (elapsed_r <= rd_step.due_time);
  end

  rsp_ram #(
    .WIDTH (STEP_W),
    .DEPTH (MAX_STEPS),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(count_r)),
    .wdata (wr_step),
    .re    (ram_re),
    .raddr (cur_r),
    .rdata (rd_bits)
  );

  rsp_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (ip_go),
    .start_temp (rd_step.start_temp),
    .end_temp   (rd_step.end_temp),
    .t          (tis_now),
    .len        (rd_step.length),
    .done       (ip_done),
    .setpoint   (ip_sp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      elapsed_r   <= '0;
      total_r     <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          // capture the item
          if (start) begin
            cmd_r   <= cmd_t'(in_cmd);
            st_r    <= in_start_temp;
            et_r    <= in_end_temp;
            len_r   <= in_step_length_ms;
            delta_r <= in_delta_ms;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // apply the command to the program state
          acc_r <= 1'b0;
          case (cmd_r)
            CMD_ADD: begin
              if (add_ok) begin
                total_r <= tot_sum[TIME_W-1:0];
                count_r <= count_r + 1'b1;
                acc_r   <= 1'b1;
              end
            end
            CMD_TICK: begin
              // saturate elapsed time on overflow and flag it
              if (el_sum[TIME_W]) begin
                elapsed_r <= '1;
              end else begin
                elapsed_r <= el_sum[TIME_W-1:0];
                acc_r     <= 1'b1;
              end
            end
            CMD_FWD: begin
              if (count_r != '0 && cur_inc < count_r) begin
                cur_r <= cur_r + 1'b1;
                acc_r <= 1'b1;
              end
            end
            CMD_BACK: begin
              if (cur_r != '0 && cur_ext <= count_r) begin
                cur_r <= cur_r - 1'b1;
                acc_r <= 1'b1;
              end
            end
            CMD_RESET: begin
              elapsed_r <= '0;
              cur_r     <= '0;
              acc_r     <= 1'b1;
            end
            CMD_CLEAR: begin
              elapsed_r <= '0;
              total_r   <= '0;
              cur_r     <= '0;
              count_r   <= '0;
              acc_r     <= 1'b1;
            end
            default: acc_r <= 1'b0;
          endcase
          state_r <= S_RD;
        end
        S_RD: begin
          // table read of the current step is in flight
          state_r <= S_CHK;
        end
        S_CHK: begin
          out_sp_r  <= '0;
          out_spv_r <= 1'b0;
          out_acc_r <= acc_r;
          out_tis_r <= '0;
          out_idx_r <= idx_pad[IDX_OUT_W-1:0];
          case (cmd_r)
            CMD_TICK: begin
              if (count_r != '0 && elapsed_r <= total_r) begin
                if (elapsed_r > rd_step.due_time) begin
                  if (cur_inc >= count_r) begin
                    out_valid_r <= 1'b1;
                    state_r     <= S_IDLE;
                  end else begin
                    // advance past the finished step and read again
                    cur_r   <= cur_r + 1'b1;
                    state_r <= S_RD;
                  end
                end else begin
                  tis_r   <= tis_now;
                  state_r <= S_INTERP;
                end
              end else begin
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
            CMD_BEGIN: begin
              if (count_r != '0 && in_range) begin
                out_sp_r  <= rd_step.start_temp;
                out_spv_r <= 1'b1;
                out_acc_r <= 1'b1;
              end else begin
                out_acc_r <= 1'b0;
              end
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            CMD_FWD, CMD_BACK: begin
              // a move lands at the start of the new step
              if (acc_r) begin
                elapsed_r <= rd_step.begin_time;
              end else begin
                out_tis_r <= tis_gen;
              end
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            default: begin
              out_tis_r   <= tis_gen;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_INTERP: begin
          if (ip_done) begin
            out_sp_r    <= ip_sp;
            out_spv_r   <= 1'b1;
            out_acc_r   <= acc_r;
            out_tis_r   <= tis_r;
            out_idx_r   <= idx_pad[IDX_OUT_W-1:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_setpoint       = out_sp_r;
  assign out_setpoint_valid = out_spv_r;
  assign out_step_index     = out_idx_r;
  assign out_accepted       = out_acc_r;
  assign out_time_in_step   = out_tis_r;

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_take_item: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r == '0 || cur_ext < count_r)
    else $error("current step beyond the step count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("step count above table depth");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_setpoint_valid |-> out_setpoint == '0)
    else $error("setpoint not zero while marked invalid");

endmodule

>>> hw/rtl/rsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/rsp_interp.sv
// Bit-serial interpolator: start + (end - start) * t / len, truncated toward zero.
`timescale 1ns / 1ps
module rsp_interp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic signed [rsp_pkg::TEMP_W-1:0] start_temp,
  input  logic signed [rsp_pkg::TEMP_W-1:0] end_temp,
  input  logic [rsp_pkg::TIME_W-1:0]        t,
  input  logic [rsp_pkg::TIME_W-1:0]        len,
  output logic                              done,
  output logic signed [rsp_pkg::TEMP_W-1:0] setpoint
);
  import rsp_pkg::*;

  localparam int CW = $clog2(MAG_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAG_W - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t                   state_r;
  logic [CW-1:0]            cnt_r;
  logic [MAG_W-1:0]         mag_r;
  logic [PROD_W-1:0]        prod_r;
  logic [TIME_W-1:0]        rem_r;
  logic [MAG_W-1:0]         quo_r;
  logic                     neg_r;
  logic signed [TEMP_W-1:0] s_r;
  logic [TIME_W-1:0]        t_r;
  logic [TIME_W-1:0]        len_r;
  logic                     done_r;
  logic signed [TEMP_W-1:0] sp_r;

  logic [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]  diff_mag;
  logic [PROD_W-1:0] prod_nxt;
  logic [TIME_W:0]   cat;
  logic [TIME_W:0]   sub;
  logic              ge;
  logic [TEMP_W-1:0] q16;
  logic [TEMP_W-1:0] q_signed;

  always_comb begin
    diff     = {end_temp[TEMP_W-1], end_temp} - {start_temp[TEMP_W-1], start_temp};
    diff_mag = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    // one partial product per cycle, MSB of the magnitude first
    prod_nxt = {prod_r[PROD_W-2:0], 1'b0} +
               (mag_r[MAG_W-1] ? {{MAG_W{1'b0}}, t_r} : {PROD_W{1'b0}});
    cat      = {rem_r, prod_r[PROD_W-1]};
    sub      = cat - {1'b0, len_r};
    ge       = (cat >= {1'b0, len_r});
    q16      = quo_r[TEMP_W-1:0];
    q_signed = neg_r ? (~q16 + 1'b1) : q16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            s_r     <= start_temp;
            t_r     <= t;
            len_r   <= len;
            neg_r   <= diff[MAG_W-1];
            mag_r   <= diff_mag;
            prod_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          mag_r  <= {mag_r[MAG_W-2:0], 1'b0};
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          // the quotient fits MAG_W bits since t never exceeds len
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '0) begin
            rem_r  <= prod_r[PROD_W-1:MAG_W];
            prod_r <= {prod_r[MAG_W-1:0], {TIME_W{1'b0}}};
            quo_r  <= '0;
          end else begin
            prod_r <= {prod_r[PROD_W-2:0], 1'b0};
            rem_r  <= ge ? sub[TIME_W-1:0] : cat[TIME_W-1:0];
            quo_r  <= {quo_r[MAG_W-2:0], ge};
          end
          if (cnt_r == CW'(MAG_W)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          sp_r    <= s_r + $signed(q_signed);
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign setpoint = sp_r;

endmodule
